### rtl/core/smrt_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and codes of the sorted mailbox route table
// no dependencies

package smrt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ID_W = 32;
	localparam int CONN_W = 3;

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_CREATE = 2'd1;
	localparam logic [1:0] FUNC_DEL_ID = 2'd2;
	localparam logic [1:0] FUNC_DEL_ALL = 2'd3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
	localparam logic [1:0] STATUS_FULL = 2'd3;

	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic [CONN_W-1:0] owner;
	} entry_t;

	typedef struct packed {
		logic [1:0] func;
		logic signed [ID_W-1:0] id;
		logic [CONN_W-1:0] conn;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [CONN_W-1:0] owner;
		logic [CNT_W-1:0] count;
	} res_t;

	typedef struct packed {
		logic id_eq;
		logic id_gt;
		logic owner_eq;
	} cmp_t;

endpackage

### rtl/core/sorted_mailbox_route_table.sv
`timescale 1ns / 1ps
// top level of the sorted mailbox route table: request intake and result register
// depends on smrt_pkg and smrt_seq

// Routing table of up to 256 signed 32-bit mailbox ids, kept in ascending order, each
// mapped to a 3-bit connection. One request is worked on at a time; req_stall is high
// from acceptance until the result has moved into the output register, which then waits
// for the consumer while the next request is taken. Every stored entry is visited through
// one single-port memory with a registered read and one shared comparator. A lookup scans
// until the id matches, create scans up to the insert point and then shifts the rest up
// one slot, and the delete operations scan and compact the whole table. A create on a
// full table answers without a scan. After reset the table is empty and usable at once;
// stored entries need no clearing.

module sorted_mailbox_route_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          func,
	input  logic signed [smrt_pkg::ID_W-1:0]    mailbox_id,
	input  logic [smrt_pkg::CONN_W-1:0]         connection,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [1:0]                          status,
	output logic [smrt_pkg::CONN_W-1:0]         found_connection,
	output logic [smrt_pkg::CNT_W-1:0]          entry_count
);
	import smrt_pkg::*;

	req_t req;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic idle;
	logic start;
	logic res_valid;
	logic res_take;

	assign req.func = func;
	assign req.id = mailbox_id;
	assign req.conn = connection;

	assign req_stall = !idle;
	assign start = req_valid && idle;
	assign res_take = res_valid && (!out_valid_q || !rsp_stall);

	smrt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (idle),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (res_take) begin
				out_valid_q <= 1'b1;
				out_q <= res;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign status = out_q.status;
	assign found_connection = out_q.owner;
	assign entry_count = out_q.count;

endmodule

### rtl/core/smrt_cmp.sv
`timescale 1ns / 1ps
// shared compare unit: one stored entry against the request operands
// depends on smrt_pkg

module smrt_cmp (
	input  smrt_pkg::entry_t entry,
	input  smrt_pkg::req_t   req,
	output smrt_pkg::cmp_t   cmp
);
	import smrt_pkg::*;

	always_comb begin
		cmp.id_eq = (entry.id == req.id);
		cmp.id_gt = (entry.id > req.id);
		cmp.owner_eq = (entry.owner == req.conn);
	end

endmodule

### rtl/core/smrt_seq.sv
`timescale 1ns / 1ps
// sequencer and single-port entry memory: scan, shift-up insert and compaction
// depends on smrt_pkg and smrt_cmp

module smrt_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  smrt_pkg::req_t req,
	output logic           idle,
	output logic           res_valid,
	input  logic           res_take,
	output smrt_pkg::res_t res
);
	import smrt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT,
		S_DONE
	} state_t;

	state_t state_q;
	req_t req_q;
	res_t res_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] idx_m1;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t wr_data;

	cmp_t cmp;
	logic hit;

	smrt_cmp u_cmp (
		.entry(rd_q),
		.req  (req_q),
		.cmp  (cmp)
	);

	assign idx_m1 = idx_q - 1'b1;
	assign hit = (req_q.func == FUNC_DEL_ALL) ? cmp.owner_eq : cmp.id_eq;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_q;
		unique case (state_q)
			S_SCAN_RD: begin
				rd_en = (idx_q != count_q);
			end
			S_SHIFT_RD: begin
				rd_en = (idx_q != pos_q);
				rd_addr = idx_m1[IDX_W-1:0];
			end
			S_SCAN_CMP: begin
				wr_en = (req_q.func == FUNC_DEL_ID || req_q.func == FUNC_DEL_ALL) && !hit;
				wr_addr = kept_q[IDX_W-1:0];
			end
			S_SHIFT_WR: begin
				wr_en = 1'b1;
			end
			S_INSERT: begin
				wr_en = 1'b1;
				wr_addr = pos_q[IDX_W-1:0];
				wr_data.id = req_q.id;
				wr_data.owner = req_q.conn;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			req_q <= '0;
			res_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			kept_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						kept_q <= '0;
						res_q.owner <= '0;
						if (req.func == FUNC_CREATE && count_q == CNT_W'(TABLE_DEPTH)) begin
							res_q.status <= STATUS_FULL;
							res_q.count <= count_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						unique case (req_q.func)
							FUNC_LOOKUP: begin
								res_q.status <= STATUS_NOT_FOUND;
								res_q.count <= count_q;
								state_q <= S_DONE;
							end
							FUNC_CREATE: begin
								pos_q <= count_q;
								state_q <= S_SHIFT_RD;
							end
							default: begin
								count_q <= kept_q;
								res_q.status <= STATUS_OK;
								res_q.count <= kept_q;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					unique case (req_q.func)
						FUNC_LOOKUP: begin
							if (cmp.id_eq) begin
								res_q.status <= STATUS_OK;
								res_q.owner <= rd_q.owner;
								res_q.count <= count_q;
								state_q <= S_DONE;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_SCAN_RD;
							end
						end
						FUNC_CREATE: begin
							if (cmp.id_gt) begin
								pos_q <= idx_q;
								idx_q <= count_q;
								state_q <= S_SHIFT_RD;
							end else if (cmp.id_eq) begin
								res_q.status <= STATUS_DUPLICATE;
								res_q.count <= count_q;
								state_q <= S_DONE;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_SCAN_RD;
							end
						end
						default: begin
							if (!hit) begin
								kept_q <= kept_q + 1'b1;
							end
							idx_q <= idx_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					endcase
				end
				S_SHIFT_RD: begin
					state_q <= (idx_q == pos_q) ? S_INSERT : S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					idx_q <= idx_m1;
					state_q <= S_SHIFT_RD;
				end
				S_INSERT: begin
					count_q <= count_q + 1'b1;
					res_q.status <= STATUS_OK;
					res_q.count <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res = res_q;

endmodule

### bench/sorted_mailbox_route_table_test.sv
`timescale 1ns / 1ps
// self-checking bench for sorted_mailbox_route_table: directed and random table requests
// with random gaps on both sides, checked against a table model kept in a scoreboard class
// depends on smrt_pkg and the block's rtl

module sorted_mailbox_route_table_test;
	import smrt_pkg::*;

	class route_table_model;
		logic signed [ID_W-1:0] ids[TABLE_DEPTH];
		logic [CONN_W-1:0] owners[TABLE_DEPTH];
		int entries = 0;
		int errors = 0;
		res_t expected_replies[$];

		function void apply_request(logic [1:0] f, logic signed [ID_W-1:0] id,
				logic [CONN_W-1:0] conn);
			res_t r;
			int pos;
			int kept;
			bit hit;
			r = '0;
			r.status = STATUS_OK;
			case (f)
				FUNC_LOOKUP: begin
					r.status = STATUS_NOT_FOUND;
					for (int i = 0; i < entries; i++) begin
						if (ids[i] == id) begin
							r.status = STATUS_OK;
							r.owner = owners[i];
							break;
						end
					end
				end
				FUNC_CREATE: begin
					if (entries >= TABLE_DEPTH) begin
						r.status = STATUS_FULL;
					end else begin
						pos = 0;
						while (pos < entries && ids[pos] < id)
							pos++;
						if (pos < entries && ids[pos] == id) begin
							r.status = STATUS_DUPLICATE;
						end else begin
							for (int j = entries; j > pos; j--) begin
								ids[j] = ids[j-1];
								owners[j] = owners[j-1];
							end
							ids[pos] = id;
							owners[pos] = conn;
							entries++;
						end
					end
				end
				default: begin
					kept = 0;
					for (int i = 0; i < entries; i++) begin
						hit = (f == FUNC_DEL_ALL) ? (owners[i] == conn) : (ids[i] == id);
						if (!hit) begin
							ids[kept] = ids[i];
							owners[kept] = owners[i];
							kept++;
						end
					end
					entries = kept;
				end
			endcase
			r.count = entries[CNT_W-1:0];
			expected_replies.push_back(r);
		endfunction

		function void compare_reply(logic [1:0] st, logic [CONN_W-1:0] own,
				logic [CNT_W-1:0] cnt);
			res_t e;
			if (expected_replies.size() == 0) begin
				$error("result with no request pending: status %0d entry_count %0d", st, cnt);
				errors++;
				return;
			end
			e = expected_replies.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (own !== e.owner) begin
				$error("found_connection: expected %0d, got %0d", e.owner, own);
				errors++;
			end
			if (cnt !== e.count) begin
				$error("entry_count: expected %0d, got %0d", e.count, cnt);
				errors++;
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] func;
	logic signed [ID_W-1:0] mailbox_id;
	logic [CONN_W-1:0] connection;
	logic rsp_valid;
	logic rsp_stall;
	logic [1:0] status;
	logic [CONN_W-1:0] found_connection;
	logic [CNT_W-1:0] entry_count;

	route_table_model routes;
	bit gaps_on;
	int idle_cycles;

	sorted_mailbox_route_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.mailbox_id(mailbox_id),
		.connection(connection),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_connection(found_connection),
		.entry_count(entry_count)
	);

	always #4 clk = ~clk;

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_request(logic [1:0] f, logic signed [ID_W-1:0] id,
			logic [CONN_W-1:0] conn);
		while (gaps_on && $urandom_range(0, 99) < 21) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		mailbox_id <= id;
		connection <= conn;
		do @(posedge clk); while (req_stall);
		routes.apply_request(f, id, conn);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (routes.expected_replies.size() != 0);
	endtask

	// mix of stored ids, edge values and fresh random ids
	function automatic logic signed [ID_W-1:0] pick_id(int known_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < known_pct && routes.entries > 0)
			return routes.ids[$urandom_range(0, routes.entries - 1)];
		if (r < known_pct + 15) begin
			case ($urandom_range(0, 3))
				0: return 32'sh80000000;
				1: return 32'sh7fffffff;
				default: return $signed($urandom_range(0, 15)) - 8;
			endcase
		end
		return $urandom;
	endfunction

	task automatic random_requests(int n, int target);
		int r;
		int c_create;
		int c_lookup;
		int c_del;
		for (int k = 0; k < n; k++) begin
			if (routes.entries < target) begin
				c_create = 45; c_lookup = 70; c_del = 90;
			end else begin
				c_create = 20; c_lookup = 50; c_del = 86;
			end
			r = $urandom_range(0, 99);
			if (r < c_create)
				send_request(FUNC_CREATE, pick_id(15), CONN_W'($urandom_range(0, 7)));
			else if (r < c_lookup)
				send_request(FUNC_LOOKUP, pick_id(60), CONN_W'($urandom_range(0, 7)));
			else if (r < c_del)
				send_request(FUNC_DEL_ID, pick_id(60), CONN_W'($urandom_range(0, 7)));
			else
				send_request(FUNC_DEL_ALL, pick_id(0), CONN_W'($urandom_range(0, 7)));
		end
	endtask

	// response side: check on rising edge, new stall at falling edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				routes.compare_reply(status, found_connection, entry_count);
			@(negedge clk);
			rsp_stall <= gaps_on && ($urandom_range(0, 99) < 21);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		routes = new();
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		func = FUNC_LOOKUP;
		mailbox_id = '0;
		connection = '0;
		rsp_stall = 1'b0;
		gaps_on = 1'b1;
		idle_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, edge ids, duplicates, misses, absent deletes
		send_request(FUNC_LOOKUP, 0, 0);
		send_request(FUNC_DEL_ID, 5, 0);
		send_request(FUNC_DEL_ALL, 0, 7);
		send_request(FUNC_CREATE, 32'sh80000000, 7);
		send_request(FUNC_CREATE, 32'sh7fffffff, 0);
		send_request(FUNC_CREATE, 0, 5);
		send_request(FUNC_CREATE, -1, 2);
		send_request(FUNC_CREATE, 1, 7);
		send_request(FUNC_CREATE, 0, 3);
		send_request(FUNC_LOOKUP, 32'sh80000000, 0);
		send_request(FUNC_LOOKUP, 32'sh7fffffff, 7);
		send_request(FUNC_LOOKUP, -1, 0);
		send_request(FUNC_LOOKUP, 2, 0);
		send_request(FUNC_DEL_ID, 0, 0);
		send_request(FUNC_DEL_ID, 0, 0);
		send_request(FUNC_LOOKUP, 0, 0);
		send_request(FUNC_DEL_ALL, 0, 7);
		send_request(FUNC_DEL_ALL, 0, 4);
		send_request(FUNC_LOOKUP, 1, 0);
		send_request(FUNC_CREATE, 32'sh55555555, 5);
		send_request(FUNC_CREATE, 32'shaaaaaaaa, 2);
		send_request(FUNC_DEL_ALL, 0, 2);
		send_request(FUNC_DEL_ALL, 0, 0);
		send_request(FUNC_DEL_ALL, 0, 5);
		wait_drained();

		// fill to capacity, then full-table requests and drain by connection
		while (routes.entries < TABLE_DEPTH)
			send_request(FUNC_CREATE, $urandom, CONN_W'($urandom_range(0, 7)));
		send_request(FUNC_CREATE, pick_id(0), 1);
		send_request(FUNC_CREATE, pick_id(100), 6);
		send_request(FUNC_LOOKUP, pick_id(100), 0);
		send_request(FUNC_LOOKUP, routes.ids[0], 0);
		send_request(FUNC_LOOKUP, routes.ids[TABLE_DEPTH-1], 0);
		send_request(FUNC_DEL_ID, pick_id(0), 0);
		send_request(FUNC_CREATE, 7, 3);
		for (int c = 0; c < 8; c++)
			send_request(FUNC_DEL_ALL, pick_id(0), CONN_W'(c));
		wait_drained();

		gaps_on = 1'b0;
		random_requests(150, 40);
		wait_drained();
		gaps_on = 1'b1;
		random_requests(200, 24);
		wait_drained();
		random_requests(150, 80);
		wait_drained();

		while (routes.expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (routes.errors == 0 && routes.expected_replies.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
